// File: rtl/vlnu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlnu_pkg
// Shared constants and request codes for the vector length/normalize unit.
// ----------------------------------------------------------------------------
package vlnu_pkg;

    // Default component width (signed Q8.8)
    localparam int COMP_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int REQ_WIDTH  = 3;
    localparam int TGT_WIDTH  = 16;
    // Quotient width: every normalize or resize quotient fits in 16 bits
    localparam int QUO_WIDTH  = 16;
    // Q1.14 scale for normalize
    localparam int NORM_SHIFT = 14;

    // Request codes
    localparam logic [REQ_WIDTH-1:0] REQ_LEN_SQ  = 3'd0;
    localparam logic [REQ_WIDTH-1:0] REQ_LEN     = 3'd1;
    localparam logic [REQ_WIDTH-1:0] REQ_NORM    = 3'd2;
    localparam logic [REQ_WIDTH-1:0] REQ_RESIZE  = 3'd3;
    localparam logic [REQ_WIDTH-1:0] REQ_DIST    = 3'd4;
    localparam logic [REQ_WIDTH-1:0] REQ_DIST_SQ = 3'd5;

endpackage

// File: rtl/vlnu_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlnu_sqrt_pipe
// Pipelined floor square root, one root bit per register stage, with a
// side payload that travels alongside.
// ----------------------------------------------------------------------------
module vlnu_sqrt_pipe #(
    parameter int RAD_WIDTH = 34,
    parameter int PAY_WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [RAD_WIDTH-1:0]     radicand,
    input  logic [PAY_WIDTH-1:0]     in_pay,
    output logic                     out_valid,
    output logic [RAD_WIDTH/2-1:0]   root,
    output logic [PAY_WIDTH-1:0]     out_pay
);

    localparam int NS = RAD_WIDTH / 2;

    logic                 vld_reg  [0:NS-1];
    logic [RAD_WIDTH-1:0] rem_reg  [0:NS-1];
    logic [NS-1:0]        root_reg [0:NS-1];
    logic [PAY_WIDTH-1:0] pay_reg  [0:NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_step
        localparam int J = NS - 1 - k;
        logic                 vld_in;
        logic [RAD_WIDTH-1:0] rem_in;
        logic [NS-1:0]        root_in;
        logic [PAY_WIDTH-1:0] pay_in;
        logic [RAD_WIDTH-1:0] trial;
        logic                 take;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = radicand;
            assign root_in = '0;
            assign pay_in  = in_pay;
        end
        else begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign pay_in  = pay_reg[k-1];
        end

        // Trial value for this bit: 2*root*2^J + 4^J
        assign trial = (RAD_WIDTH'(root_in) << (J + 1)) | (RAD_WIDTH'(1) << (2 * J));
        assign take  = (rem_in >= trial);

        // Advance valid bit
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[k] <= 1'b0;
            end
            else begin
                vld_reg[k] <= vld_in;
            end
        end

        // Advance partial remainder and root
        always_ff @(posedge clk) begin
            rem_reg[k]  <= take ? (rem_in - trial) : rem_in;
            root_reg[k] <= take ? (root_in | (NS'(1) << J)) : root_in;
            pay_reg[k]  <= pay_in;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign root      = root_reg[NS-1];
    assign out_pay   = pay_reg[NS-1];

endmodule

// File: rtl/vlnu_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlnu_div_pipe
// Three-lane restoring divider with a shared divisor, one quotient bit per
// register stage, with a side payload.
// ----------------------------------------------------------------------------
module vlnu_div_pipe #(
    parameter int NUM_WIDTH = 33,
    parameter int DEN_WIDTH = 17,
    parameter int PAY_WIDTH = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [2:0][NUM_WIDTH-1:0]            num,
    input  logic [DEN_WIDTH-1:0]                 den,
    input  logic [PAY_WIDTH-1:0]                 in_pay,
    output logic                                 out_valid,
    output logic [2:0][vlnu_pkg::QUO_WIDTH-1:0]  quo,
    output logic [PAY_WIDTH-1:0]                 out_pay
);

    localparam int QW = vlnu_pkg::QUO_WIDTH;

    logic                            vld_reg [0:QW-1];
    logic [2:0][NUM_WIDTH-1:0]       rem_reg [0:QW-1];
    logic [2:0][QW-1:0]              quo_reg [0:QW-1];
    logic [DEN_WIDTH-1:0]            den_reg [0:QW-1];
    logic [PAY_WIDTH-1:0]            pay_reg [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int J = QW - 1 - k;
        logic                      vld_in;
        logic [2:0][NUM_WIDTH-1:0] rem_in;
        logic [2:0][QW-1:0]        quo_in;
        logic [DEN_WIDTH-1:0]      den_in;
        logic [PAY_WIDTH-1:0]      pay_in;
        logic [NUM_WIDTH-1:0]      trial;
        logic [2:0][NUM_WIDTH-1:0] rem_nx;
        logic [2:0][QW-1:0]        quo_nx;

        if (k == 0) begin : g_first
            assign vld_in = in_valid;
            assign rem_in = num;
            assign quo_in = '0;
            assign den_in = den;
            assign pay_in = in_pay;
        end
        else begin : g_next
            assign vld_in = vld_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign pay_in = pay_reg[k-1];
        end

        assign trial = NUM_WIDTH'(den_in) << J;

        // Compare and subtract in each lane
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                if (rem_in[i] >= trial) begin
                    rem_nx[i] = rem_in[i] - trial;
                    quo_nx[i] = quo_in[i] | (QW'(1) << J);
                end
                else begin
                    rem_nx[i] = rem_in[i];
                    quo_nx[i] = quo_in[i];
                end
            end
        end

        // Advance valid bit
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[k] <= 1'b0;
            end
            else begin
                vld_reg[k] <= vld_in;
            end
        end

        // Advance lane state
        always_ff @(posedge clk) begin
            rem_reg[k] <= rem_nx;
            quo_reg[k] <= quo_nx;
            den_reg[k] <= den_in;
            pay_reg[k] <= pay_in;
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];

endmodule

// File: rtl/vec3_length_normalize_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_length_normalize_unit_top
// Fixed-point 3-vector unit: squared length, length, normalize, resize,
// distance and squared distance.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is taken every cycle (busy stays low) and
// its result appears with a one-cycle done strobe. The pipeline is made of
// three front stages (difference/magnitude, products, sum), the square root
// pipeline with one stage per root bit (COMP_WIDTH+1), the 16-stage divider
// and the output register. The receiver cannot stall, so results must be
// taken as they come.
// ----------------------------------------------------------------------------
module vec3_length_normalize_unit_top #(
    parameter int COMP_WIDTH = vlnu_pkg::COMP_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [vlnu_pkg::REQ_WIDTH-1:0]     req_type,
    input  logic signed [COMP_WIDTH-1:0]       a_x,
    input  logic signed [COMP_WIDTH-1:0]       a_y,
    input  logic signed [COMP_WIDTH-1:0]       a_z,
    input  logic signed [COMP_WIDTH-1:0]       b_x,
    input  logic signed [COMP_WIDTH-1:0]       b_y,
    input  logic signed [COMP_WIDTH-1:0]       b_z,
    input  logic [vlnu_pkg::TGT_WIDTH-1:0]     target_length,
    output logic                               done,
    output logic [2*COMP_WIDTH+1:0]            scalar,
    output logic signed [COMP_WIDTH-1:0]       out_x,
    output logic signed [COMP_WIDTH-1:0]       out_y,
    output logic signed [COMP_WIDTH-1:0]       out_z,
    output logic                               zero_vector,
    output logic                               saturated
);

    localparam int W   = COMP_WIDTH;
    localparam int MW  = W + 1;                    // magnitude / root width
    localparam int SW  = 2 * W + 2;                // squared length width
    localparam int NW  = W + 17;                   // divider numerator width
    localparam int QW  = vlnu_pkg::QUO_WIDTH;
    localparam int RW  = vlnu_pkg::REQ_WIDTH;
    localparam int TW  = vlnu_pkg::TGT_WIDTH;
    localparam int LW  = ((W > QW) ? W : QW) + 1;  // clamp compare width

    typedef struct packed {
        logic [RW-1:0]        req;
        logic [SW-1:0]        sq;
        logic [2:0][NW-1:0]   num;
        logic [2:0]           neg;
        logic                 zero;
    } sq_pay_t;

    typedef struct packed {
        logic [RW-1:0]        req;
        logic [SW-1:0]        sq;
        logic [MW-1:0]        len;
        logic [2:0]           neg;
        logic                 zero;
    } dv_pay_t;

    // Pipelined: never refuse a transaction
    assign busy = 1'b0;

    // ---------------- stage 0: difference and magnitude ----------------
    logic              s0_vld_reg;
    logic [RW-1:0]     s0_req_reg;
    logic [TW-1:0]     s0_tgt_reg;
    logic [2:0]        s0_neg_reg;
    logic [2:0][MW-1:0] s0_mag_reg;
    logic [2:0]        s0_neg_next;
    logic [2:0][MW-1:0] s0_mag_next;

    always_comb begin
        logic signed [W:0] av [3];
        logic signed [W:0] bv [3];
        logic signed [W:0] d;
        logic              use_b;
        use_b = (req_type == vlnu_pkg::REQ_DIST) || (req_type == vlnu_pkg::REQ_DIST_SQ);
        av[0] = MW'(a_x);
        av[1] = MW'(a_y);
        av[2] = MW'(a_z);
        bv[0] = MW'(b_x);
        bv[1] = MW'(b_y);
        bv[2] = MW'(b_z);
        for (int i = 0; i < 3; i++) begin
            d = use_b ? (av[i] - bv[i]) : av[i];
            s0_neg_next[i] = d[W];
            s0_mag_next[i] = d[W] ? MW'(-d) : MW'(d);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s0_vld_reg <= 1'b0;
        end
        else begin
            s0_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk) begin
        s0_req_reg <= req_type;
        s0_tgt_reg <= target_length;
        s0_neg_reg <= s0_neg_next;
        s0_mag_reg <= s0_mag_next;
    end

    // ---------------- stage 1: products ----------------
    logic               s1_vld_reg;
    logic [RW-1:0]      s1_req_reg;
    logic [2:0]         s1_neg_reg;
    logic               s1_zero_reg;
    logic [2:0][SW-1:0] s1_sqr_reg;
    logic [2:0][NW-1:0] s1_num_reg;
    logic [2:0][NW-1:0] s1_num_next;
    logic [2:0][SW-1:0] s1_sqr_next;

    // Square each magnitude and select normalize or resize numerator per lane
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s1_sqr_next[i] = SW'(s0_mag_reg[i]) * SW'(s0_mag_reg[i]);
            if (s0_req_reg == vlnu_pkg::REQ_NORM) begin
                s1_num_next[i] = NW'(s0_mag_reg[i]) << vlnu_pkg::NORM_SHIFT;
            end
            else begin
                s1_num_next[i] = NW'(s0_mag_reg[i]) * NW'(s0_tgt_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_vld_reg <= 1'b0;
        end
        else begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        s1_req_reg  <= s0_req_reg;
        s1_neg_reg  <= s0_neg_reg;
        s1_zero_reg <= ((s0_mag_reg[0] | s0_mag_reg[1] | s0_mag_reg[2]) == '0);
        s1_sqr_reg  <= s1_sqr_next;
        s1_num_reg  <= s1_num_next;
    end

    // ---------------- stage 2: sum of squares ----------------
    logic    s2_vld_reg;
    sq_pay_t s2_pay_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_vld_reg <= 1'b0;
        end
        else begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        s2_pay_reg.req  <= s1_req_reg;
        s2_pay_reg.sq   <= s1_sqr_reg[0] + s1_sqr_reg[1] + s1_sqr_reg[2];
        s2_pay_reg.num  <= s1_num_reg;
        s2_pay_reg.neg  <= s1_neg_reg;
        s2_pay_reg.zero <= s1_zero_reg;
    end

    // ---------------- square root ----------------
    logic          rt_vld;
    logic [MW-1:0] rt_len;
    sq_pay_t       rt_pay;

    vlnu_sqrt_pipe #(
        .RAD_WIDTH (SW),
        .PAY_WIDTH ($bits(sq_pay_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .radicand  (s2_pay_reg.sq),
        .in_pay    (s2_pay_reg),
        .out_valid (rt_vld),
        .root      (rt_len),
        .out_pay   (rt_pay)
    );

    // ---------------- divide ----------------
    dv_pay_t            dv_pay_in;
    logic               dv_vld;
    logic [2:0][QW-1:0] dv_quo;
    dv_pay_t            dv_pay;

    assign dv_pay_in.req  = rt_pay.req;
    assign dv_pay_in.sq   = rt_pay.sq;
    assign dv_pay_in.len  = rt_len;
    assign dv_pay_in.neg  = rt_pay.neg;
    assign dv_pay_in.zero = rt_pay.zero;

    vlnu_div_pipe #(
        .NUM_WIDTH (NW),
        .DEN_WIDTH (MW),
        .PAY_WIDTH ($bits(dv_pay_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_vld),
        .num       (rt_pay.num),
        .den       (rt_len),
        .in_pay    (dv_pay_in),
        .out_valid (dv_vld),
        .quo       (dv_quo),
        .out_pay   (dv_pay)
    );

    // ---------------- result select and clamp ----------------
    logic [SW-1:0]     scalar_next;
    logic [2:0][W-1:0] vec_next;
    logic              zero_next;
    logic              sat_next;

    always_comb begin
        logic [LW-1:0] q;
        logic [LW-1:0] lim;
        scalar_next = '0;
        vec_next    = '0;
        zero_next   = dv_pay.zero;
        sat_next    = 1'b0;
        q           = '0;
        lim         = '0;
        case (dv_pay.req)
            vlnu_pkg::REQ_LEN_SQ, vlnu_pkg::REQ_DIST_SQ:
            begin
                scalar_next = dv_pay.sq;
            end
            vlnu_pkg::REQ_LEN, vlnu_pkg::REQ_DIST:
            begin
                scalar_next = SW'(dv_pay.len);
            end
            vlnu_pkg::REQ_NORM:
            begin
                if (!dv_pay.zero) begin
                    for (int i = 0; i < 3; i++) begin
                        q = LW'(dv_quo[i]);
                        vec_next[i] = dv_pay.neg[i] ? W'(-q) : W'(q);
                    end
                end
            end
            vlnu_pkg::REQ_RESIZE:
            begin
                if (!dv_pay.zero) begin
                    for (int i = 0; i < 3; i++) begin
                        q   = LW'(dv_quo[i]);
                        lim = (LW'(1) << (W - 1)) - LW'(!dv_pay.neg[i]);
                        // Clamp to the signed component range
                        if (q > lim) begin
                            q        = lim;
                            sat_next = 1'b1;
                        end
                        vec_next[i] = dv_pay.neg[i] ? W'(-q) : W'(q);
                    end
                end
            end
            default:
            begin
                zero_next = 1'b0;
            end
        endcase
    end

    // ---------------- output register ----------------
    logic              done_reg;
    logic [SW-1:0]     scalar_reg;
    logic [2:0][W-1:0] vec_reg;
    logic              zero_reg;
    logic              sat_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk) begin
        scalar_reg <= scalar_next;
        vec_reg    <= vec_next;
        zero_reg   <= zero_next;
        sat_reg    <= sat_next;
    end

    assign done        = done_reg;
    assign scalar      = scalar_reg;
    assign out_x       = vec_reg[0];
    assign out_y       = vec_reg[1];
    assign out_z       = vec_reg[2];
    assign zero_vector = zero_reg;
    assign saturated   = sat_reg;

endmodule

// File: rtl/vlnu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlnu_checker
// Port-level checks on the vector unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
module vlnu_checker #(
    parameter int COMP_WIDTH = vlnu_pkg::COMP_WIDTH_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [2*COMP_WIDTH+1:0]     scalar,
    input logic [COMP_WIDTH-1:0]       out_x,
    input logic [COMP_WIDTH-1:0]       out_y,
    input logic [COMP_WIDTH-1:0]       out_z,
    input logic                        zero_vector,
    input logic                        saturated
);

    localparam int LAT = COMP_WIDTH + 21;

    // Every accepted transaction returns after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing at fixed latency");

    // No result without a transaction in flight
    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a transaction");

    // Zero vector results carry zero components
    a_zero_comp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_vector) |-> (out_x == '0 && out_y == '0 && out_z == '0))
        else $error("zero vector with nonzero components");

    // Saturation only on resize: no scalar, nonzero vector
    a_sat_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (!zero_vector && scalar == '0))
        else $error("saturation flag on a non-resize result");

endmodule

bind vec3_length_normalize_unit_top vlnu_checker #(
    .COMP_WIDTH (COMP_WIDTH)
) u_vlnu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .scalar      (scalar),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .zero_vector (zero_vector),
    .saturated   (saturated)
);

// File: test/vec3_length_normalize_unit_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_length_normalize_unit_top_tb
// Self-checking bench for the 3-vector unit: a driver issues request
// transactions from a queue, a monitor compares every done strobe with the
// oldest predicted result.
// ----------------------------------------------------------------------------
module vec3_length_normalize_unit_top_tb;

    localparam int CW = 16;
    localparam int SW = 2 * CW + 2;
    localparam int LATENCY = CW + 21;

    typedef struct packed {
        logic [vlnu_pkg::REQ_WIDTH-1:0] req;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bz;
        logic [vlnu_pkg::TGT_WIDTH-1:0] tgt;
    } vec_req_t;

    typedef struct packed {
        logic [SW-1:0]        scl;
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic signed [CW-1:0] oz;
        logic                 zv;
        logic                 sat;
    } vec_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [vlnu_pkg::REQ_WIDTH-1:0] req_type = '0;
    logic signed [CW-1:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [CW-1:0] b_x = '0, b_y = '0, b_z = '0;
    logic [vlnu_pkg::TGT_WIDTH-1:0] target_length = '0;
    logic done;
    logic [SW-1:0] scalar;
    logic signed [CW-1:0] out_x, out_y, out_z;
    logic zero_vector, saturated;

    vec_req_t pending_reqs[$];
    vec_res_t expected_results[$];
    int       idle_pct = 0;
    int       mismatches = 0;
    bit       stim_done = 1'b0;

    vec3_length_normalize_unit_top #(.COMP_WIDTH(CW)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .target_length(target_length),
        .done(done), .scalar(scalar), .out_x(out_x), .out_y(out_y),
        .out_z(out_z), .zero_vector(zero_vector), .saturated(saturated)
    );

    always #2 clk = ~clk;

    // Floor square root, bit by bit
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Compute the result of one request
    function automatic vec_res_t vector_result(vec_req_t r);
        vec_res_t        res;
        longint          c[3];
        longint unsigned m[3];
        longint unsigned sq, len, q, lim;
        bit              zero;
        res = '0;
        c[0] = r.ax; c[1] = r.ay; c[2] = r.az;
        if (r.req == vlnu_pkg::REQ_DIST || r.req == vlnu_pkg::REQ_DIST_SQ) begin
            c[0] -= r.bx; c[1] -= r.by; c[2] -= r.bz;
        end
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (c[i] < 0) ? -c[i] : c[i];
            sq += m[i] * m[i];
        end
        zero = (m[0] | m[1] | m[2]) == 0;
        len = floor_sqrt(sq);
        case (r.req)
            vlnu_pkg::REQ_LEN_SQ, vlnu_pkg::REQ_DIST_SQ: res.scl = sq[SW-1:0];
            vlnu_pkg::REQ_LEN, vlnu_pkg::REQ_DIST:       res.scl = len[SW-1:0];
            vlnu_pkg::REQ_NORM:
                if (!zero) begin
                    for (int i = 0; i < 3; i++) begin
                        q = (m[i] << vlnu_pkg::NORM_SHIFT) / len;
                        if (c[i] < 0) q = -q;
                        if (i == 0) res.ox = q[CW-1:0];
                        if (i == 1) res.oy = q[CW-1:0];
                        if (i == 2) res.oz = q[CW-1:0];
                    end
                end
            vlnu_pkg::REQ_RESIZE:
                if (!zero) begin
                    for (int i = 0; i < 3; i++) begin
                        q = (m[i] * r.tgt) / len;
                        lim = (c[i] < 0) ? 64'd32768 : 64'd32767;
                        if (q > lim) begin
                            q = lim;
                            res.sat = 1'b1;
                        end
                        if (c[i] < 0) q = -q;
                        if (i == 0) res.ox = q[CW-1:0];
                        if (i == 1) res.oy = q[CW-1:0];
                        if (i == 2) res.oz = q[CW-1:0];
                    end
                end
            default: zero = 1'b0;
        endcase
        res.zv = zero;
        return res;
    endfunction

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic vec_req_t rand_req();
        vec_req_t r;
        r.req = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
        r.ax = rand_comp(); r.ay = rand_comp(); r.az = rand_comp();
        if ($urandom_range(0, 7) == 0) begin
            r.bx = r.ax; r.by = r.ay; r.bz = r.az;
        end
        else begin
            r.bx = rand_comp(); r.by = rand_comp(); r.bz = rand_comp();
        end
        if ($urandom_range(0, 9) == 0) r.ax = 0;
        if ($urandom_range(0, 9) == 0) begin
            r.ay = 0; r.az = 0;
        end
        r.tgt = ($urandom_range(0, 9) == 0) ? 16'(($urandom_range(0, 1)) * 16'hffff)
                                            : 16'($urandom);
        return r;
    endfunction

    function automatic vec_req_t mk_req(logic [2:0] t, logic [15:0] ax, logic [15:0] ay,
                                        logic [15:0] az, logic [15:0] bx, logic [15:0] by,
                                        logic [15:0] bz, logic [15:0] tg);
        vec_req_t r;
        r.req = t; r.ax = ax; r.ay = ay; r.az = az;
        r.bx = bx; r.by = by; r.bz = bz; r.tgt = tg;
        return r;
    endfunction

    // Fill the queue: directed corners, then random phases
    initial begin
        for (int t = 0; t < 8; t++) begin
            pending_reqs.push_back(mk_req(3'(t), 16'h8000, 16'h8000, 16'h8000,
                                          16'h7fff, 16'h7fff, 16'h7fff, 16'hffff));
            pending_reqs.push_back(mk_req(3'(t), 0, 0, 0, 0, 0, 0, 16'h0100));
        end
        pending_reqs.push_back(mk_req(vlnu_pkg::REQ_RESIZE, 16'h0100, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(vlnu_pkg::REQ_RESIZE, 16'h0001, 16'h8000, 0,
                                      0, 0, 0, 16'hffff));
        pending_reqs.push_back(mk_req(vlnu_pkg::REQ_NORM, 16'h0001, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(vlnu_pkg::REQ_NORM, 16'hffff, 16'hffff, 16'h0001,
                                      0, 0, 0, 0));
        pending_reqs.push_back(mk_req(vlnu_pkg::REQ_DIST, 16'h1234, 16'h0, 16'h5,
                                      16'h1234, 0, 5, 0));
        pending_reqs.push_back(mk_req(vlnu_pkg::REQ_DIST_SQ, 16'h7fff, 16'h7fff, 16'h7fff,
                                      16'h8000, 16'h8000, 16'h8000, 0));
        @(posedge rst_n);
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 87 : (ph == 3) ? 33 : 0;
            for (int i = 0; i < 490; i++) pending_reqs.push_back(rand_req());
            while (pending_reqs.size() != 0) @(posedge clk);
        end
        stim_done = 1'b1;
    end

    // Drive request transactions
    always @(posedge clk)
    begin
        if (start && !busy) expected_results.push_back(vector_result(
            mk_req(req_type, a_x, a_y, a_z, b_x, b_y, b_z, target_length)));
        if ((start && busy) || !rst_n) begin
            // hold the current transaction
        end
        else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            vec_req_t r;
            r = pending_reqs.pop_front();
            start <= 1'b1;
            req_type <= r.req;
            a_x <= r.ax; a_y <= r.ay; a_z <= r.az;
            b_x <= r.bx; b_y <= r.by; b_z <= r.bz;
            target_length <= r.tgt;
        end
        else begin
            start <= 1'b0;
        end
    end

    // Check each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end
            else begin
                vec_res_t e;
                vec_res_t a;
                e = expected_results.pop_front();
                a = '{scalar, out_x, out_y, out_z, zero_vector, saturated};
                if (a !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp scl=%0d xyz=%0d,%0d,%0d zv=%b sat=%b",
                                 e.scl, e.ox, e.oy, e.oz, e.zv, e.sat,
                                 " got scl=%0d xyz=%0d,%0d,%0d zv=%b sat=%b",
                                 a.scl, a.ox, a.oy, a.oz, a.zv, a.sat);
                end
            end
        end
    end

    // Reset, then wait for the drain
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        @(posedge clk);
        while (start || expected_results.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Bound the run
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
